// ----- src/tfn_pkg.sv -----
// Shared constants for the triangle face normal core.
package tfn_pkg;

  localparam int unsigned CoordWidthDef  = 24;
  localparam int unsigned NormalWidthDef = 16;
  // Cross product magnitudes are normalized to this many bits before the square root.
  localparam int unsigned NormBits       = 31;
  localparam int unsigned SumBits        = 2 * NormBits + 2;
  localparam int unsigned RootBits       = SumBits / 2;

endpackage

// ----- src/triangle_face_normal_core.sv -----
// Triangle face normal core: pipelined cross product, normalization, square root and divide.
//
// One triangle may be started in every clock cycle; busy is always low and the receiver
// cannot stall. Each result appears on the result ports for one cycle with valid_o high,
// in order, after passing through 7 front stages (edges, products, cross
// product, exponent, shift, squares, sum), RootBits square root stages, one dividend stage,
// NORMAL_WIDTH divider stages and one output stage. The square root and divider pipelines
// produce one result bit per stage.
module triangle_face_normal_core import tfn_pkg::*; #(
  parameter int unsigned COORD_WIDTH  = CoordWidthDef,
  parameter int unsigned NORMAL_WIDTH = NormalWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [COORD_WIDTH-1:0]  ax_i,
  input  logic signed [COORD_WIDTH-1:0]  ay_i,
  input  logic signed [COORD_WIDTH-1:0]  az_i,
  input  logic signed [COORD_WIDTH-1:0]  bx_i,
  input  logic signed [COORD_WIDTH-1:0]  by_i,
  input  logic signed [COORD_WIDTH-1:0]  bz_i,
  input  logic signed [COORD_WIDTH-1:0]  cx_i,
  input  logic signed [COORD_WIDTH-1:0]  cy_i,
  input  logic signed [COORD_WIDTH-1:0]  cz_i,
  output logic                           valid_o,
  output logic signed [NORMAL_WIDTH-1:0] nx_o,
  output logic signed [NORMAL_WIDTH-1:0] ny_o,
  output logic signed [NORMAL_WIDTH-1:0] nz_o,
  output logic                           degenerate_o
);

  localparam int unsigned EW  = COORD_WIDTH + 1;
  localparam int unsigned PW  = 2 * EW;
  localparam int unsigned XW  = PW + 1;
  localparam int unsigned BLW = $clog2(XW + 1);
  localparam int unsigned F   = NORMAL_WIDTH - 1;
  localparam int unsigned QW  = NORMAL_WIDTH;
  localparam int unsigned NNW = NormBits + F + 1;
  localparam int unsigned RW  = RootBits + 2;
  localparam int unsigned DW  = RootBits + 1;

  assign busy = 1'b0;

  // Stage 1: edges.
  logic                 v1_q;
  logic signed [EW-1:0] e1_q [3];
  logic signed [EW-1:0] e2_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    e1_q[0] <= EW'(bx_i) - EW'(ax_i);
    e1_q[1] <= EW'(by_i) - EW'(ay_i);
    e1_q[2] <= EW'(bz_i) - EW'(az_i);
    e2_q[0] <= EW'(cx_i) - EW'(ax_i);
    e2_q[1] <= EW'(cy_i) - EW'(ay_i);
    e2_q[2] <= EW'(cz_i) - EW'(az_i);
  end

  // Stage 2: six products.
  logic                 v2_q;
  logic signed [PW-1:0] p_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q[0] <= PW'(e1_q[1]) * PW'(e2_q[2]);
    p_q[1] <= PW'(e1_q[2]) * PW'(e2_q[1]);
    p_q[2] <= PW'(e1_q[2]) * PW'(e2_q[0]);
    p_q[3] <= PW'(e1_q[0]) * PW'(e2_q[2]);
    p_q[4] <= PW'(e1_q[0]) * PW'(e2_q[1]);
    p_q[5] <= PW'(e1_q[1]) * PW'(e2_q[0]);
  end

  // Stage 3: cross product as sign and magnitude.
  logic          v3_q;
  logic [XW-1:0] mag3_q [3];
  logic [2:0]    neg3_q;
  logic signed [XW-1:0] diff_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff_d[i] = XW'(p_q[2*i]) - XW'(p_q[2*i+1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      neg3_q[i] <= diff_d[i][XW-1];
      mag3_q[i] <= diff_d[i][XW-1] ? XW'(-diff_d[i]) : XW'(diff_d[i]);
    end
  end

  // Stage 4: common bit length of the three magnitudes.
  logic           v4_q;
  logic [XW-1:0]  mag4_q [3];
  logic [2:0]     neg4_q;
  logic [BLW-1:0] blen4_q;
  logic [BLW-1:0] blen_d;
  logic [XW-1:0]  or_d;

  always_comb begin
    or_d   = mag3_q[0] | mag3_q[1] | mag3_q[2];
    blen_d = '0;
    for (int i = 0; i < XW; i++) begin
      if (or_d[i]) begin
        blen_d = BLW'(i + 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mag4_q  <= mag3_q;
    neg4_q  <= neg3_q;
    blen4_q <= blen_d;
  end

  // Stage 5: shift so the largest magnitude fills NormBits bits.
  logic                v5_q;
  logic [NormBits-1:0] m5_q [3];
  logic [2:0]          neg5_q;
  logic                deg5_q;
  logic [XW+NormBits-1:0] sh_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh_d[i] = {mag4_q[i], NormBits'(0)} >> blen4_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      m5_q[i] <= sh_d[i][NormBits-1:0];
    end
    neg5_q <= neg4_q;
    deg5_q <= (blen4_q == '0);
  end

  // Stage 6: squares.
  logic                  v6_q;
  logic [NormBits-1:0]   m6_q [3];
  logic [2:0]            neg6_q;
  logic                  deg6_q;
  logic [2*NormBits-1:0] sq6_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sq6_q[i] <= (2*NormBits)'(m5_q[i]) * (2*NormBits)'(m5_q[i]);
    end
    m6_q   <= m5_q;
    neg6_q <= neg5_q;
    deg6_q <= deg5_q;
  end

  // Stage 7: sum of squares.
  logic                v7_q;
  logic [NormBits-1:0] m7_q [3];
  logic [2:0]          neg7_q;
  logic                deg7_q;
  logic [SumBits-1:0]  sum7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else begin
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sum7_q <= SumBits'(sq6_q[0]) + SumBits'(sq6_q[1]) + SumBits'(sq6_q[2]);
    m7_q   <= m6_q;
    neg7_q <= neg6_q;
    deg7_q <= deg6_q;
  end

  // Square root, one root bit per stage, most significant first.
  logic                sv_q   [RootBits];
  logic [SumBits-1:0]  srad_q [RootBits];
  logic [RW-1:0]       srem_q [RootBits];
  logic [RootBits-1:0] sroot_q[RootBits];
  logic [NormBits-1:0] sm_q   [RootBits][3];
  logic [2:0]          sneg_q [RootBits];
  logic                sdeg_q [RootBits];

  for (genvar k = 0; k < RootBits; k++) begin : g_sqrt
    logic                v_in;
    logic [SumBits-1:0]  rad_in;
    logic [RW-1:0]       rem_in;
    logic [RootBits-1:0] root_in;
    logic [NormBits-1:0] m_in [3];
    logic [2:0]          neg_in;
    logic                deg_in;
    logic [RW-1:0]       rem_sh;
    logic [RW-1:0]       trial;

    if (k == 0) begin : g_first
      assign v_in    = v7_q;
      assign rad_in  = sum7_q;
      assign rem_in  = '0;
      assign root_in = '0;
      assign m_in    = m7_q;
      assign neg_in  = neg7_q;
      assign deg_in  = deg7_q;
    end else begin : g_next
      assign v_in    = sv_q[k-1];
      assign rad_in  = srad_q[k-1];
      assign rem_in  = srem_q[k-1];
      assign root_in = sroot_q[k-1];
      assign m_in    = sm_q[k-1];
      assign neg_in  = sneg_q[k-1];
      assign deg_in  = sdeg_q[k-1];
    end

    assign rem_sh = {rem_in[RW-3:0], rad_in[SumBits-1 -: 2]};
    assign trial  = {root_in, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k] <= 1'b0;
      end else begin
        sv_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      srad_q[k] <= {rad_in[SumBits-3:0], 2'b00};
      if (rem_sh >= trial) begin
        srem_q[k]  <= rem_sh - trial;
        sroot_q[k] <= {root_in[RootBits-2:0], 1'b1};
      end else begin
        srem_q[k]  <= rem_sh;
        sroot_q[k] <= {root_in[RootBits-2:0], 1'b0};
      end
      sm_q[k]   <= m_in;
      sneg_q[k] <= neg_in;
      sdeg_q[k] <= deg_in;
    end
  end

  // Dividend stage: m * 2^F plus half the length, for rounding.
  logic                vn_q;
  logic [NNW-1:0]      num_q [3];
  logic [RootBits-1:0] len_q;
  logic [2:0]          negn_q;
  logic                degn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vn_q <= 1'b0;
    end else begin
      vn_q <= sv_q[RootBits-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      num_q[i] <= {1'b0, sm_q[RootBits-1][i], F'(0)}
                + NNW'(sroot_q[RootBits-1] >> 1);
    end
    len_q  <= sroot_q[RootBits-1];
    negn_q <= sneg_q[RootBits-1];
    degn_q <= sdeg_q[RootBits-1];
  end

  // Restoring divider, one quotient bit per stage for all three components.
  logic                dv_q   [QW];
  logic [DW-1:0]       drem_q [QW][3];
  logic [QW-1:0]       dlo_q  [QW][3];
  logic [QW-1:0]       dquo_q [QW][3];
  logic [RootBits-1:0] dlen_q [QW];
  logic [2:0]          dneg_q [QW];
  logic                ddeg_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic                v_in;
    logic [DW-1:0]       rem_in [3];
    logic [QW-1:0]       lo_in  [3];
    logic [QW-1:0]       quo_in [3];
    logic [RootBits-1:0] len_in;
    logic [2:0]          neg_in;
    logic                deg_in;

    if (k == 0) begin : g_first
      assign v_in   = vn_q;
      assign len_in = len_q;
      assign neg_in = negn_q;
      assign deg_in = degn_q;
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_in[i] = DW'(num_q[i][NNW-1:QW]);
        assign lo_in[i]  = num_q[i][QW-1:0];
        assign quo_in[i] = '0;
      end
    end else begin : g_next
      assign v_in   = dv_q[k-1];
      assign rem_in = drem_q[k-1];
      assign lo_in  = dlo_q[k-1];
      assign quo_in = dquo_q[k-1];
      assign len_in = dlen_q[k-1];
      assign neg_in = dneg_q[k-1];
      assign deg_in = ddeg_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else begin
        dv_q[k] <= v_in;
      end
    end

    for (genvar i = 0; i < 3; i++) begin : g_step
      logic [DW-1:0] r2;
      assign r2 = {rem_in[i][DW-2:0], lo_in[i][QW-1]};

      always_ff @(posedge clk_i) begin
        dlo_q[k][i] <= lo_in[i] << 1;
        if (r2 >= DW'(len_in)) begin
          drem_q[k][i] <= r2 - DW'(len_in);
          dquo_q[k][i] <= {quo_in[i][QW-2:0], 1'b1};
        end else begin
          drem_q[k][i] <= r2;
          dquo_q[k][i] <= {quo_in[i][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      dlen_q[k] <= len_in;
      dneg_q[k] <= neg_in;
      ddeg_q[k] <= deg_in;
    end
  end

  // Output stage: saturate, apply sign, zero a degenerate triangle.
  localparam logic [QW-1:0] One = QW'(1) << F;
  logic [NORMAL_WIDTH-1:0] res_d [3];
  logic [QW-1:0]           qs_d  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs_d[i] = dquo_q[QW-1][i];
      if (dneg_q[QW-1][i]) begin
        if (qs_d[i] > One) begin
          qs_d[i] = One;
        end
        res_d[i] = NORMAL_WIDTH'(-qs_d[i]);
      end else begin
        if (qs_d[i] > One - 1'b1) begin
          qs_d[i] = One - 1'b1;
        end
        res_d[i] = NORMAL_WIDTH'(qs_d[i]);
      end
      if (ddeg_q[QW-1]) begin
        res_d[i] = '0;
      end
    end
  end

  logic                    valid_q;
  logic [NORMAL_WIDTH-1:0] nx_q, ny_q, nz_q;
  logic                    deg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= dv_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    nx_q  <= res_d[0];
    ny_q  <= res_d[1];
    nz_q  <= res_d[2];
    deg_q <= ddeg_q[QW-1];
  end

  assign valid_o      = valid_q;
  assign nx_o         = nx_q;
  assign ny_o         = ny_q;
  assign nz_o         = nz_q;
  assign degenerate_o = deg_q;

endmodule
